// ===== sv/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point arithmetic unit.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MIN = 3'd4;
  localparam logic [2:0] OP_MAX = 3'd5;

  // CLS_NONE covers the unused opcodes, which give a zero result.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_MIN,
    CLS_MAX
  } cls_t;

  typedef struct packed {
    cls_t                     cls;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     lt;
    logic                     eq;
    logic                     gt;
    logic                     dz;
  } entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== sv/fpa_ifs.sv =====
// Request and response channel interfaces of the fixed-point unit.
`timescale 1ns / 1ps

interface fpa_req_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               operation;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     a_less;
  logic                     a_equal;
  logic                     a_greater;
  logic                     divide_by_zero;

  modport source (output valid, output result_value, output a_less, output a_equal,
                  output a_greater, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input a_less, input a_equal,
                  input a_greater, input divide_by_zero, output ready);
endinterface

// ===== sv/fpa_front.sv =====
// Front end: accepts requests, decodes the opcode and computes compare and divide-by-zero flags.
`timescale 1ns / 1ps

module fpa_front (
  fpa_req_if.sink          req,
  input  logic             full,
  output logic             push,
  output fpa_pkg::entry_t  push_data
);
  import fpa_pkg::*;

  cls_t cls;

  always_comb begin
    case (req.operation)
      OP_ADD:  cls = CLS_ADD;
      OP_SUB:  cls = CLS_SUB;
      OP_MUL:  cls = CLS_MUL;
      OP_DIV:  cls = CLS_DIV;
      OP_MIN:  cls = CLS_MIN;
      OP_MAX:  cls = CLS_MAX;
      default: cls = CLS_NONE;
    endcase
  end

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    push_data.cls = cls;
    push_data.a   = req.operand_a;
    push_data.b   = req.operand_b;
    push_data.lt  = req.operand_a < req.operand_b;
    push_data.eq  = req.operand_a == req.operand_b;
    push_data.gt  = req.operand_a > req.operand_b;
    push_data.dz  = (cls == CLS_DIV) && (req.operand_b == '0);
  end

endmodule

// ===== sv/fpa_queue.sv =====
// Small FIFO between the front end and the execution back end.
`timescale 1ns / 1ps

module fpa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fpa_pkg::entry_t  push_data,
  output logic             full,
  input  logic             pop,
  output fpa_pkg::entry_t  pop_data,
  output logic             empty
);
  import fpa_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/fpa_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, signed fixed-point.
`timescale 1ns / 1ps

module fpa_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [fpa_pkg::DATA_W-1:0] a,
  input  logic signed [fpa_pkg::DATA_W-1:0] b,
  input  logic                             ack,
  output logic                             done,
  output logic [fpa_pkg::DATA_W-1:0]        quot
);
  import fpa_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [NUM_W-1:0]  num;
  logic [DATA_W-1:0] den;
  logic              neg;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              q_bit;

  assign mag_a   = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign mag_b   = b[DATA_W-1] ? (~b + 1'b1) : b;
  assign shifted = {rem, num[NUM_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign q_bit   = !diff[DATA_W];

  assign done = state == ST_DONE;
  assign quot = neg ? (~num[DATA_W-1:0] + 1'b1) : num[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (start) begin
      state <= ST_RUN;
      cnt   <= CNT_W'(NUM_W - 1);
      rem   <= '0;
      num   <= {mag_a, {FRAC_BITS{1'b0}}};
      den   <= mag_b;
      neg   <= a[DATA_W-1] != b[DATA_W-1];
    end else begin
      case (state)
        ST_RUN: begin
          rem <= q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
          num <= {num[NUM_W-2:0], q_bit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/fpa_back.sv =====
// Back end: executes queued operations in order and holds the response register.
`timescale 1ns / 1ps

module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  fpa_pkg::entry_t  head,
  input  logic             empty,
  output logic             pop,
  fpa_rsp_if.source        rsp
);
  import fpa_pkg::*;

  logic                       s1_valid;
  entry_t                     s1;
  logic signed [2*DATA_W-1:0] s1_prod;
  logic [DATA_W-1:0]          s1_res;

  logic                       rsp_valid;
  logic [DATA_W-1:0]          rsp_result;
  logic                       rsp_lt;
  logic                       rsp_eq;
  logic                       rsp_gt;
  logic                       rsp_dz;

  logic                       wait_div;
  logic                       advance;
  logic                       div_start;
  logic                       div_done;
  logic [DATA_W-1:0]          div_quot;
  logic [DATA_W-1:0]          simple_res;
  logic signed [2*DATA_W-1:0] prod_next;
  logic signed [2*DATA_W-1:0] prod_shift;
  logic [DATA_W-1:0]          result_next;

  assign wait_div  = (s1.cls == CLS_DIV) && !s1.dz;
  assign advance   = s1_valid && (!wait_div || div_done) && (!rsp_valid || rsp.ready);
  assign pop       = !empty && (!s1_valid || advance);
  assign div_start = pop && (head.cls == CLS_DIV) && !head.dz;
  assign prod_next = head.a * head.b;

  always_comb begin
    case (head.cls)
      CLS_ADD: simple_res = head.a + head.b;
      CLS_SUB: simple_res = head.a - head.b;
      CLS_MIN: simple_res = (head.lt || head.eq) ? head.a : head.b;
      CLS_MAX: simple_res = (head.gt || head.eq) ? head.a : head.b;
      default: simple_res = '0;
    endcase
  end

  assign prod_shift = s1_prod >>> FRAC_BITS;

  always_comb begin
    case (s1.cls)
      CLS_MUL: result_next = prod_shift[DATA_W-1:0];
      CLS_DIV: result_next = s1.dz ? '0 : div_quot;
      default: result_next = s1_res;
    endcase
  end

  fpa_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (head.a),
    .b     (head.b),
    .ack   (advance),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      s1      <= head;
      s1_prod <= prod_next;
      s1_res  <= simple_res;
    end
    if (advance) begin
      rsp_result <= result_next;
      rsp_lt     <= s1.lt;
      rsp_eq     <= s1.eq;
      rsp_gt     <= s1.gt;
      rsp_dz     <= s1.dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.result_value   = rsp_result;
  assign rsp.a_less         = rsp_lt;
  assign rsp.a_equal        = rsp_eq;
  assign rsp.a_greater      = rsp_gt;
  assign rsp.divide_by_zero = rsp_dz;

endmodule

// ===== sv/fixed_point_q24_8_alu.sv =====
// Top level of the Q24.8 fixed-point arithmetic unit.
// Path: a request is written into the queue, then moves through the execute stage
//   (s1) and into the response register; a divide waits in s1 for the divider.
// Throughput: one transfer per cycle for non-divide operations while rsp.ready is high;
//   a divide by nonzero holds s1 until the divider ends (one quotient bit per cycle).
// Reset: synchronous rst empties the queue, the execute stage and the response register.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  fpa_req_if.sink    req,
  fpa_rsp_if.source  rsp
);
  import fpa_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  entry_t push_data;
  entry_t head;

  fpa_front u_front (
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  fpa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
